@@ rtl/core/rla_pkg.sv @@
// Shared types and constants of the running LCM accumulator.
package rla_pkg;

  // Width of an input rate and of the magnitudes taken from it
  localparam int unsigned RATE_W = 16;
  localparam int unsigned MAG_W  = 16;

  // Width of the delivered running value
  localparam int unsigned LCM_W  = 32;

  // Operation of the shared add/subtract unit
  typedef enum logic {
    ALU_SUB,
    ALU_ADD
  } alu_op_e;

  // Result beat handed from the sequencer to the output register
  typedef struct packed {
    logic [LCM_W-1:0] lcm_value;
    logic             overflow;
  } result_t;

endpackage

@@ rtl/core/running_lcm_accumulator_unit.sv @@
// Top level of the running LCM accumulator: stream ports and output register.
//
//  channel   dir  payload                              handshake
//  s_axis    in   tdata: rate; tuser: start_req        tvalid/tready
//  m_axis    out  tdata: lcm_value; tuser: overflow    tvalid/tready
//
// A start item, or a fold with a zero operand, goes from idle straight to the
// result state, and the input stays busy until the output register takes it.
// Other folds pass through a magnitude step if the running value is negative,
// then the binary GCD, divide and multiply steps, all through the one shared
// add/subtract unit.
// s_axis_tready is high only while the sequencer is idle; the output register
// lets the next beat in while a result waits. Asynchronous reset clears the
// running value and the overflow flag; no clearing pass.
module running_lcm_accumulator_unit #(
  parameter int unsigned RESULT_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] rate
  input  logic        s_axis_tuser,   // [0] start_req
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] lcm_value
  output logic        m_axis_tuser    // [0] overflow
);

  logic             res_valid;
  logic             res_ready;
  rla_pkg::result_t res;
  logic             out_valid_q;
  rla_pkg::result_t out_res_q;

  rla_core #(
    .RESULT_WIDTH (RESULT_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .rate_i      (s_axis_tdata),
    .start_i     (s_axis_tuser),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: free when empty or being drained this cycle
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
      out_res_q   <= res;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_res_q.lcm_value;
  assign m_axis_tuser  = out_res_q.overflow;

endmodule

@@ rtl/core/rla_addsub.sv @@
// Shared add/subtract unit used for every arithmetic step of the sequencer.
module rla_addsub #(
  parameter int unsigned WIDTH = 48
) (
  input  rla_pkg::alu_op_e   op_i,
  input  logic [WIDTH-1:0]   x_i,
  input  logic [WIDTH-1:0]   y_i,
  output logic [WIDTH-1:0]   res_o,
  output logic               borrow_o
);

  logic [WIDTH-1:0] y_sel;
  logic             cin;
  logic [WIDTH:0]   sum;

  // Subtract as x + ~y + 1; carry out low means x < y
  always_comb begin
    y_sel = (op_i == rla_pkg::ALU_SUB) ? ~y_i : y_i;
    cin   = (op_i == rla_pkg::ALU_SUB);
    sum   = {1'b0, x_i} + {1'b0, y_sel} + {{WIDTH{1'b0}}, cin};
  end

  assign res_o    = sum[WIDTH-1:0];
  assign borrow_o = (op_i == rla_pkg::ALU_SUB) && !sum[WIDTH];

endmodule

@@ rtl/core/rla_core.sv @@
// Sequencer and datapath registers: binary GCD, restoring divide, shift-add multiply.
module rla_core #(
  parameter int unsigned RESULT_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  output logic                         req_ready_o,
  input  logic [rla_pkg::RATE_W-1:0]   rate_i,
  input  logic                         start_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output rla_pkg::result_t             res_o
);

  localparam int unsigned RW = RESULT_WIDTH;
  localparam int unsigned MW = rla_pkg::MAG_W;
  localparam int unsigned PW = RW + MW;
  localparam int unsigned CW = $clog2(RW + 1);
  localparam int unsigned KW = $clog2(MW);
  localparam logic [RW-1:0] RvMax = {1'b0, {(RW-1){1'b1}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAG,
    ST_GCD,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_e;

  state_e           state_q;
  logic [RW-1:0]    rv_q;
  logic             ovf_q;
  logic [RW-1:0]    ma_q;     // |running|, then dividend / quotient shift register
  logic [RW-1:0]    a_q;      // GCD operand a
  logic [MW-1:0]    b_q;      // GCD operand b, then the GCD itself
  logic [MW-1:0]    mb_q;     // |rate|, shifted out MSB first while multiplying
  logic [MW-1:0]    rem_q;    // partial remainder of the divide
  logic [PW-1:0]    acc_q;    // product accumulator
  logic [CW-1:0]    cnt_q;
  logic [KW-1:0]    k_q;      // common factors of two

  logic [MW-1:0]    rate_mag;
  rla_pkg::alu_op_e alu_op;
  logic [PW-1:0]    alu_x;
  logic [PW-1:0]    alu_y;
  logic [PW-1:0]    alu_res;
  logic             alu_borrow;
  logic [RW+rla_pkg::LCM_W-1:0] rv_wide;

  // Magnitude of the incoming rate; -32768 gives 32768
  assign rate_mag = rate_i[rla_pkg::RATE_W-1] ? MW'(~rate_i + 1'b1) : MW'(rate_i);

  // Operand selection for the shared unit
  always_comb begin
    alu_op = rla_pkg::ALU_SUB;
    alu_x  = '0;
    alu_y  = '0;
    unique case (state_q)
      ST_MAG: begin
        alu_y = PW'(rv_q);
      end
      ST_GCD: begin
        alu_x = PW'(a_q);
        alu_y = PW'(b_q);
      end
      ST_DIV: begin
        alu_x = PW'({rem_q, ma_q[RW-1]});
        alu_y = PW'(b_q);
      end
      ST_MUL: begin
        alu_op = rla_pkg::ALU_ADD;
        alu_x  = {acc_q[PW-2:0], 1'b0};
        alu_y  = mb_q[MW-1] ? PW'(ma_q) : '0;
      end
      default: ;
    endcase
  end

  rla_addsub #(
    .WIDTH (PW)
  ) u_addsub (
    .op_i     (alu_op),
    .x_i      (alu_x),
    .y_i      (alu_y),
    .res_o    (alu_res),
    .borrow_o (alu_borrow)
  );

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rv_q    <= '0;
      ovf_q   <= 1'b0;
      ma_q    <= '0;
      a_q     <= '0;
      b_q     <= '0;
      mb_q    <= '0;
      rem_q   <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
      k_q     <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (req_valid_i) begin
            mb_q <= rate_mag;
            b_q  <= rate_mag;
            k_q  <= '0;
            ma_q <= rv_q;
            a_q  <= rv_q;
            if (start_i) begin
              rv_q    <= RW'($signed(rate_i));
              ovf_q   <= 1'b0;
              state_q <= ST_DONE;
            end else if ((rv_q == '0) || (rate_i == '0)) begin
              rv_q    <= '0;
              state_q <= ST_DONE;
            end else if (rv_q[RW-1]) begin
              state_q <= ST_MAG;
            end else begin
              state_q <= ST_GCD;
            end
          end
        end
        ST_MAG: begin
          ma_q    <= alu_res[RW-1:0];
          a_q     <= alu_res[RW-1:0];
          state_q <= ST_GCD;
        end
        ST_GCD: begin
          if (a_q == '0) begin
            b_q     <= b_q << k_q;
            rem_q   <= '0;
            cnt_q   <= CW'(RW);
            state_q <= ST_DIV;
          end else if (!a_q[0] && !b_q[0]) begin
            a_q <= a_q >> 1;
            b_q <= b_q >> 1;
            k_q <= KW'(k_q + 1'b1);
          end else if (!a_q[0]) begin
            a_q <= a_q >> 1;
          end else if (!b_q[0]) begin
            b_q <= b_q >> 1;
          end else if (alu_borrow) begin
            // a < b: swap, subtract on the next step
            a_q <= RW'(b_q);
            b_q <= a_q[MW-1:0];
          end else begin
            a_q <= alu_res[RW-1:0];
          end
        end
        ST_DIV: begin
          rem_q <= alu_borrow ? alu_x[MW-1:0] : alu_res[MW-1:0];
          ma_q  <= {ma_q[RW-2:0], !alu_borrow};
          if (cnt_q == CW'(1)) begin
            acc_q   <= '0;
            cnt_q   <= CW'(MW);
            state_q <= ST_MUL;
          end else begin
            cnt_q <= CW'(cnt_q - 1'b1);
          end
        end
        ST_MUL: begin
          acc_q <= alu_res;
          mb_q  <= mb_q << 1;
          if (cnt_q == CW'(1)) begin
            // saturate where the product leaves the signed range
            if ((alu_res >> (RW - 1)) != '0) begin
              rv_q  <= RvMax;
              ovf_q <= 1'b1;
            end else begin
              rv_q <= alu_res[RW-1:0];
            end
            state_q <= ST_DONE;
          end else begin
            cnt_q <= CW'(cnt_q - 1'b1);
          end
        end
        ST_DONE: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rv_wide          = {{rla_pkg::LCM_W{1'b0}}, rv_q};
  assign req_ready_o      = (state_q == ST_IDLE);
  assign res_valid_o      = (state_q == ST_DONE);
  assign res_o.lcm_value  = rv_wide[rla_pkg::LCM_W-1:0];
  assign res_o.overflow   = ovf_q;

endmodule

@@ rtl/core/rla_checker.sv @@
// Port-level checks of the running LCM accumulator, bound to the top level.
module rla_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  logic in_beat;
  assign in_beat = s_axis_tvalid && s_axis_tready;

  // A stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // Busy after taking an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !s_axis_tready)
    else $error("second beat taken while busy");

  // A start item, passed on while the output is ready, shows its rate with the flag cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && s_axis_tuser) ##1 m_axis_tready |=>
      m_axis_tvalid && (m_axis_tdata[15:0] == $past(s_axis_tdata, 2)) && !m_axis_tuser)
    else $error("start item not loaded as given");

  // Folding a zero rate, passed on while the output is ready, gives zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && !s_axis_tuser && (s_axis_tdata == 16'd0)) ##1 m_axis_tready |=>
      m_axis_tvalid && (m_axis_tdata == 32'd0))
    else $error("zero fold did not give zero");

endmodule

bind running_lcm_accumulator_unit rla_checker u_rla_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ test/running_lcm_accumulator_unit_tb.sv @@
// Self-checking testbench of the running LCM accumulator: directed table, random sets, stalls.
module running_lcm_accumulator_unit_tb;

  localparam int unsigned RATE_W     = rla_pkg::RATE_W;
  localparam int unsigned LCM_W      = rla_pkg::LCM_W;
  localparam int unsigned NUM_ITEMS  = 1750;
  localparam int unsigned GAP_MAX    = 16;
  localparam int unsigned HOLD_OFF   = 400;
  localparam int unsigned DRAIN_WAIT = 300;
  localparam int unsigned NUM_ROWS   = 24;

  // Directed stimulus row; the expected beat is only used where has_exp is set
  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic              start_req;
    logic              has_exp;
    logic [LCM_W-1:0]  exp_lcm;
    logic              exp_ovf;
  } lcm_row_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [RATE_W-1:0] s_axis_tdata  = '0;
  logic              s_axis_tuser  = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [LCM_W-1:0]  m_axis_tdata;
  logic              m_axis_tuser;

  // Predictor state: running value and sticky saturation flag
  logic [LCM_W-1:0]  lcm_running = '0;
  logic              lcm_ovf     = 1'b0;

  rla_pkg::result_t  lcm_expect_q[$];
  int unsigned       err_count     = 0;
  int unsigned       send_gap_max  = GAP_MAX;
  int unsigned       recv_gap_max  = GAP_MAX;
  bit                hold_off_req  = 1'b0;

  // Directed rows: extremes, zero operands, negatives, saturation and its clearing
  lcm_row_t dir_rows [0:NUM_ROWS-1] = '{
    '{16'd5,      1'b0, 1'b1, 32'd0,          1'b0}, // fold before any start
    '{16'h7FFF,   1'b1, 1'b1, 32'd32767,      1'b0},
    '{16'h8000,   1'b1, 1'b1, 32'hFFFF_8000,  1'b0},
    '{16'h8000,   1'b0, 1'b0, 32'd0,          1'b0}, // most negative against itself
    '{16'h7FFF,   1'b0, 1'b0, 32'd0,          1'b0},
    '{16'd3,      1'b0, 1'b0, 32'd0,          1'b0}, // saturates
    '{16'd0,      1'b0, 1'b1, 32'd0,          1'b1}, // zero keeps the sticky flag
    '{16'd0,      1'b1, 1'b1, 32'd0,          1'b0},
    '{16'd7,      1'b0, 1'b1, 32'd0,          1'b0}, // zero running value
    '{16'hFFFA,   1'b1, 1'b1, 32'hFFFF_FFFA,  1'b0},
    '{16'd4,      1'b0, 1'b0, 32'd0,          1'b0},
    '{16'hFFF7,   1'b0, 1'b0, 32'd0,          1'b0},
    '{16'd1,      1'b0, 1'b0, 32'd0,          1'b0},
    '{16'd1,      1'b1, 1'b1, 32'd1,          1'b0},
    '{16'hFFFF,   1'b0, 1'b0, 32'd0,          1'b0},
    '{16'h7FFF,   1'b1, 1'b1, 32'd32767,      1'b0},
    '{16'h7FFE,   1'b0, 1'b0, 32'd0,          1'b0},
    '{16'h7FFD,   1'b0, 1'b0, 32'd0,          1'b0},
    '{16'h7FFC,   1'b0, 1'b0, 32'd0,          1'b0}, // fold into saturated value
    '{16'd12,     1'b1, 1'b1, 32'd12,         1'b0}, // start clears the flag
    '{16'h5555,   1'b0, 1'b0, 32'd0,          1'b0},
    '{16'h2AAA,   1'b0, 1'b0, 32'd0,          1'b0},
    '{16'h8000,   1'b0, 1'b0, 32'd0,          1'b0}, // saturates again
    '{16'd0,      1'b0, 1'b1, 32'd0,          1'b1}
  };

  running_lcm_accumulator_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Generous ceiling: the worst fold plus both gaps, several times over
  initial begin
    #25_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Fold one rate into the running LCM, or load it on a start; returns the new beat
  function automatic rla_pkg::result_t lcm_fold(input logic [RATE_W-1:0] rate,
                                                input logic start_req);
    logic [LCM_W-1:0]  neg_run;
    logic [RATE_W-1:0] neg_rate;
    longint unsigned   mag_run;
    longint unsigned   mag_rate;
    longint unsigned   x;
    longint unsigned   y;
    longint unsigned   t;
    longint unsigned   quot;
    rla_pkg::result_t  res;
    if (start_req) begin
      lcm_running = {{(LCM_W-RATE_W){rate[RATE_W-1]}}, rate};
      lcm_ovf     = 1'b0;
    end else begin
      neg_run  = -lcm_running;
      neg_rate = -rate;
      mag_run  = lcm_running[LCM_W-1] ? 64'(neg_run) : 64'(lcm_running);
      mag_rate = rate[RATE_W-1] ? 64'(neg_rate) : 64'(rate);
      if (mag_run == 0 || mag_rate == 0) begin
        lcm_running = '0;
      end else begin
        // Euclid on the magnitudes
        x = mag_run;
        y = mag_rate;
        while (y != 0) begin
          t = y;
          y = x % y;
          x = t;
        end
        quot = mag_run / x;
        if (quot > 64'h7FFF_FFFF / mag_rate) begin
          lcm_running = 32'h7FFF_FFFF;
          lcm_ovf     = 1'b1;
        end else begin
          lcm_running = LCM_W'(quot * mag_rate);
        end
      end
    end
    res.lcm_value = lcm_running;
    res.overflow  = lcm_ovf;
    return res;
  endfunction

  // Rate mix: mostly small magnitudes so sets run a while before saturating
  function automatic logic [RATE_W-1:0] pick_rate();
    int unsigned sel;
    logic [RATE_W-1:0] r;
    sel = $urandom_range(0, 99);
    if (sel < 35)      r = RATE_W'($urandom_range(1, 64));
    else if (sel < 50) r = RATE_W'(-$urandom_range(1, 64));
    else if (sel < 70) r = RATE_W'($urandom_range(0, 1) ? $urandom_range(1, 1000)
                                                        : -$urandom_range(1, 1000));
    else if (sel < 88) r = RATE_W'($urandom);
    else if (sel < 93) r = '0;
    else begin
      case ($urandom_range(0, 3))
        0:       r = 16'h8000;
        1:       r = 16'h7FFF;
        2:       r = 16'hFFFF;
        default: r = 16'h0001;
      endcase
    end
    return r;
  endfunction

  // Offer one beat after a random gap; record its expectation on acceptance
  task automatic send_beat(input logic [RATE_W-1:0] rate, input logic start_req,
                           input logic has_exp, input rla_pkg::result_t exp_res);
    int unsigned      gap;
    rla_pkg::result_t pred;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rate;
    s_axis_tuser  <= start_req;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = lcm_fold(rate, start_req);
    lcm_expect_q.push_back(has_exp ? exp_res : pred);
  endtask

  // Sender stops offering until every outstanding result has been taken
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (lcm_expect_q.size() != 0);
  endtask

  // Sender: directed table, then random sets
  initial begin
    int unsigned      n_sent;
    int unsigned      set_len;
    logic             start_req;
    rla_pkg::result_t exp_res;
    rla_pkg::result_t no_exp;
    no_exp = '0;
    n_sent = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);

    foreach (dir_rows[i]) begin
      exp_res.lcm_value = dir_rows[i].exp_lcm;
      exp_res.overflow  = dir_rows[i].exp_ovf;
      send_beat(dir_rows[i].rate, dir_rows[i].start_req, dir_rows[i].has_exp, exp_res);
      n_sent++;
    end

    while (n_sent < NUM_ITEMS) begin
      set_len = $urandom_range(1, 8);
      for (int unsigned k = 0; k < set_len; k++) begin
        // mostly proper sets; occasionally a set without its start or a stray restart
        start_req = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
        send_beat(pick_rate(), start_req, 1'b0, no_exp);
        n_sent++;
        if (n_sent % 150 == 0) begin
          send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
          recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
        end
        if (n_sent == 400) begin
          send_gap_max = 0;
          hold_off_req = 1'b1;
        end
        if (n_sent == 900 || n_sent == 1400) wait_drained();
      end
    end

    s_axis_tvalid <= 1'b0;
    while (lcm_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off on request, field-by-field check
  initial begin
    int unsigned      stall;
    rla_pkg::result_t exp_res;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = $urandom_range(0, recv_gap_max);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall        = HOLD_OFF;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (lcm_expect_q.size() == 0) begin
        $display("%0t: unexpected beat lcm_value %h overflow %b",
                 $time, m_axis_tdata, m_axis_tuser);
        err_count++;
      end else begin
        exp_res = lcm_expect_q.pop_front();
        if (m_axis_tdata !== exp_res.lcm_value) begin
          $display("%0t: lcm_value expected %h actual %h",
                   $time, exp_res.lcm_value, m_axis_tdata);
          err_count++;
        end
        if (m_axis_tuser !== exp_res.overflow) begin
          $display("%0t: overflow expected %b actual %b",
                   $time, exp_res.overflow, m_axis_tuser);
          err_count++;
        end
      end
    end
  end

endmodule
